FILE: rtl/kea_pkg.sv
package kea_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int VAL_W          = 35;
	localparam int PROD_W         = 2 * VAL_W;
	localparam int DVD_W          = 66;
	localparam int DVS_W          = 32;
	localparam int CORDIC_STEPS   = 30;

	localparam logic [7:0]  ITER_RESET = 8'd50;
	localparam logic [15:0] TOL_RESET  = 16'd4;

	localparam logic [63:0] TWOPI_RED = 64'h006487ED5110B461;
	localparam logic signed [VAL_W-1:0] ONE_Q30    = 35'sd1073741824;
	localparam logic signed [VAL_W-1:0] HALF_Q30   = 35'sd536870912;
	localparam logic signed [VAL_W-1:0] UB_Q29     = 35'sd3373259425;
	localparam logic signed [VAL_W-1:0] PI_Q30     = 35'sd3373259426;
	localparam logic signed [VAL_W-1:0] TWOPI_Q30  = 35'sd6746518852;
	localparam logic signed [VAL_W-1:0] HALFPI_Q30 = 35'sd1686629713;
	localparam logic signed [VAL_W-1:0] CORDIC_K   = 35'sd652032874;

	localparam logic [0:0] REG_MAX_ITER = 1'b0;
	localparam logic [0:0] REG_TOL      = 1'b1;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_LIMIT     = 2'd2;

	typedef enum logic [3:0] {
		OP_ES, OP_EC, OP_E2, OP_C2, OP_T2, OP_T3, OP_G2, OP_F, OP_D
	} mul_op_t;

	function automatic logic signed [VAL_W-1:0] atan_q30(input logic [4:0] i);
		logic signed [VAL_W-1:0] r;
		unique case (i)
			5'd0:  r = 35'sh3243F6A8;
			5'd1:  r = 35'sh1DAC6705;
			5'd2:  r = 35'sh0FADBAFC;
			5'd3:  r = 35'sh07F56EA6;
			5'd4:  r = 35'sh03FEAB76;
			5'd5:  r = 35'sh01FFD55B;
			5'd6:  r = 35'sh00FFFAAA;
			5'd7:  r = 35'sh007FFF55;
			5'd8:  r = 35'sh003FFFEA;
			5'd9:  r = 35'sh001FFFFD;
			5'd10: r = 35'sh000FFFFF;
			5'd11: r = 35'sh0007FFFF;
			5'd12: r = 35'sh0003FFFF;
			5'd13: r = 35'sh0001FFFF;
			5'd14: r = 35'sh0000FFFF;
			5'd15: r = 35'sh00007FFF;
			5'd16: r = 35'sh00003FFF;
			5'd17: r = 35'sh00001FFF;
			5'd18: r = 35'sh00000FFF;
			5'd19: r = 35'sh000007FF;
			5'd20: r = 35'sh000003FF;
			5'd21: r = 35'sh000001FF;
			5'd22: r = 35'sh000000FF;
			5'd23: r = 35'sh0000007F;
			5'd24: r = 35'sh0000003F;
			5'd25: r = 35'sh0000001F;
			5'd26: r = 35'sh0000000F;
			5'd27: r = 35'sh00000008;
			5'd28: r = 35'sh00000004;
			5'd29: r = 35'sh00000002;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/kepler_eccentric_anomaly_solver.sv
// channel   direction  handshake          payload
// cmd       in         start & !busy      eccentricity, mean_anomaly
// result    out        done (one cycle)   eccentric_anomaly, status, iterations_used
// cfg       in         cfg_we             cfg_index, cfg_data
//
// one item at a time: modulo 2*pi reduction, cordic of M, series guess, first residual,
// check, then per newton step a divide, a cordic and control states.
// invalid eccentricity: done rises in the cycle right after the accepting edge.
// reset clears control and restores max_iterations 50, tolerance_lsb 4.
// done is a one-cycle strobe; the receiver cannot stall it.
module kepler_eccentric_anomaly_solver #(
	parameter int DATA_WIDTH = kea_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] eccentricity,
	input  logic signed [DATA_WIDTH-1:0] mean_anomaly,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [15:0]                  cfg_data,
	output logic                         done,
	output logic [31:0]                  eccentric_anomaly,
	output logic [1:0]                   status,
	output logic [7:0]                   iterations_used
);
	import kea_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_RED  = 10'b0000000010,
		S_RFIN = 10'b0000000100,
		S_CRDM = 10'b0000001000,
		S_MUL  = 10'b0000010000,
		S_MWB  = 10'b0000100000,
		S_CRDE = 10'b0001000000,
		S_CHK  = 10'b0010000000,
		S_DIV  = 10'b0100000000,
		S_UPD  = 10'b1000000000
	} state_t;

	state_t state_q;
	mul_op_t op_q;

	logic [7:0]  maxit_q;
	logic [15:0] tol_q;

	logic signed [63:0] e_ext, m_ext;
	logic signed [31:0] e_sat, m_sat;

	logic signed [VAL_W-1:0] e_q, m_q, sm_q, cm_q, es_q, ec_q, e2_q, c2_q, t2_q, t3_q;
	logic signed [VAL_W-1:0] se_q, ce_q, ea_q;
	logic signed [VAL_W:0]   f_q;
	logic [7:0]  cnt_q;
	logic        neg_q;
	logic [63:0] red_q, mod_q;
	logic [2:0]  k_q;

	logic signed [VAL_W-1:0] ma, mb, t4;
	logic signed [VAL_W+1:0] c3;
	logic signed [PROD_W-1:0] prod;
	logic signed [VAL_W-1:0] p30;
	logic signed [VAL_W:0]   p31;
	logic signed [VAL_W+1:0] gsum;
	logic signed [VAL_W+1:0] e_guess;
	logic signed [VAL_W-1:0] e_clamp, d_raw;
	logic [63:0] r_fin;
	logic [VAL_W:0] f_abs;
	logic exceed;
	logic signed [DVD_W+1:0] nv;
	logic signed [VAL_W-1:0] e_next;

	logic cst_q, dst_q, c_done, d_done;
	logic [31:0] cang_q;
	logic signed [VAL_W-1:0] c_sin, c_cos;
	logic [DVD_W-1:0] dvd_q, quot;
	logic [DVS_W-1:0] dvs_q;

	logic done_q;
	logic [31:0] res_ea_q;
	logic [1:0]  res_st_q;
	logic [7:0]  res_it_q;

	// inputs up to 64 bits wide saturate to the 32-bit formats
	always_comb begin
		e_ext = 64'(eccentricity);
		m_ext = 64'(mean_anomaly);
		if (e_ext > 64'sd2147483647)       e_sat = 32'sh7FFFFFFF;
		else if (e_ext < -64'sd2147483648) e_sat = 32'sh80000000;
		else                               e_sat = e_ext[31:0];
		if (m_ext > 64'sd2147483647)       m_sat = 32'sh7FFFFFFF;
		else if (m_ext < -64'sd2147483648) m_sat = 32'sh80000000;
		else                               m_sat = m_ext[31:0];
	end

	assign c3 = (VAL_W+2)'(c2_q) + (VAL_W+2)'({c2_q, 1'b0});
	assign t4 = VAL_W'((c3 >>> 1) - (VAL_W+2)'(HALF_Q30));

	always_comb begin
		unique case (op_q)
			OP_ES:   begin ma = e_q;  mb = sm_q; end
			OP_EC:   begin ma = e_q;  mb = cm_q; end
			OP_E2:   begin ma = e_q;  mb = e_q;  end
			OP_C2:   begin ma = cm_q; mb = cm_q; end
			OP_T2:   begin ma = es_q; mb = ec_q; end
			OP_T3:   begin ma = e2_q; mb = es_q; end
			OP_G2:   begin ma = t3_q; mb = t4;   end
			OP_F:    begin ma = e_q;  mb = se_q; end
			OP_D:    begin ma = e_q;  mb = ce_q; end
			default: begin ma = '0;   mb = '0;   end
		endcase
	end

	kea_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(prod));

	assign p30 = VAL_W'(prod >>> 30);
	assign p31 = (VAL_W+1)'(prod >>> 31);

	// series guess from the g2 product, clamped to [0, ub]
	always_comb begin
		gsum = (VAL_W+2)'(es_q) + (VAL_W+2)'(t2_q) + (VAL_W+2)'(p30);
		e_guess = (VAL_W+2)'(m_q) + (gsum >>> 1);
		if (e_guess < 0)                          e_clamp = '0;
		else if (e_guess > (VAL_W+2)'(UB_Q29))    e_clamp = UB_Q29;
		else                                      e_clamp = VAL_W'(e_guess);
		d_raw = ONE_Q30 - p30;
		if (d_raw < 35'sd1)
			d_raw = 35'sd1;
	end

	assign r_fin  = (neg_q && red_q != 64'd0) ? TWOPI_RED - red_q : red_q;
	assign f_abs  = f_q[VAL_W] ? (VAL_W+1)'(-f_q) : (VAL_W+1)'(f_q);
	assign exceed = f_abs > (VAL_W+1)'(tol_q);

	// newton update, a step out of range becomes a bisection toward the bound
	always_comb begin
		nv = (DVD_W+2)'(ea_q) - (f_q[VAL_W] ? -(DVD_W+2)'(quot) : (DVD_W+2)'(quot));
		if (nv > (DVD_W+2)'(UB_Q29))
			e_next = VAL_W'(((DVD_W+2)'(ea_q) + (DVD_W+2)'(UB_Q29)) >>> 1);
		else if (nv < 0)
			e_next = ea_q >>> 1;
		else
			e_next = VAL_W'(nv);
	end

	kea_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cst_q), .angle(cang_q),
		.done(c_done), .sin_v(c_sin), .cos_v(c_cos)
	);

	kea_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dst_q), .dividend(dvd_q),
		.divisor(dvs_q), .done(d_done), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxit_q <= ITER_RESET;
			tol_q   <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_ITER: maxit_q <= cfg_data[7:0];
				REG_TOL:      tol_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_ES;
			cst_q   <= 1'b0;
			dst_q   <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			cst_q  <= 1'b0;
			dst_q  <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						k_q   <= '0;
						if (e_sat < 0 || e_sat >= 32'sd1073741824) begin
							done_q   <= 1'b1;
							res_ea_q <= '0;
							res_st_q <= ST_INVALID;
							res_it_q <= '0;
						end else begin
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					if (red_q >= mod_q)
						red_q <= red_q - mod_q;
					mod_q <= mod_q >> 1;
					k_q   <= k_q + 3'd1;
					if (k_q == 3'd7)
						state_q <= S_RFIN;
				end
				S_RFIN: begin
					m_q     <= VAL_W'(r_fin >> 27);
					cang_q  <= 32'(r_fin >> 27);
					cst_q   <= 1'b1;
					state_q <= S_CRDM;
				end
				S_CRDM: begin
					if (c_done) begin
						sm_q    <= c_sin;
						cm_q    <= c_cos;
						op_q    <= OP_ES;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_MWB;
				S_MWB: begin
					state_q <= S_MUL;
					unique case (op_q)
						OP_ES: begin es_q <= p30; op_q <= OP_EC; end
						OP_EC: begin ec_q <= p30; op_q <= OP_E2; end
						OP_E2: begin e2_q <= p30; op_q <= OP_C2; end
						OP_C2: begin c2_q <= p30; op_q <= OP_T2; end
						OP_T2: begin t2_q <= p30; op_q <= OP_T3; end
						OP_T3: begin t3_q <= p30; op_q <= OP_G2; end
						OP_G2: begin
							ea_q    <= e_clamp;
							cang_q  <= e_clamp[31:0];
							cst_q   <= 1'b1;
							state_q <= S_CRDE;
						end
						OP_F: begin
							f_q     <= (VAL_W+1)'(ea_q) - (VAL_W+1)'(m_q) - p31;
							state_q <= S_CHK;
						end
						OP_D: begin
							dvd_q   <= {f_abs, 30'd0};
							dvs_q   <= DVS_W'(d_raw);
							dst_q   <= 1'b1;
							state_q <= S_DIV;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_CRDE: begin
					if (c_done) begin
						se_q    <= c_sin;
						ce_q    <= c_cos;
						op_q    <= OP_F;
						state_q <= S_MUL;
					end
				end
				S_CHK: begin
					if (cnt_q < maxit_q && exceed) begin
						op_q    <= OP_D;
						state_q <= S_MUL;
					end else begin
						done_q   <= 1'b1;
						res_ea_q <= ea_q[31:0];
						res_st_q <= (cnt_q == maxit_q && exceed) ? ST_LIMIT : ST_CONVERGED;
						res_it_q <= cnt_q;
						state_q  <= S_IDLE;
					end
				end
				S_DIV: begin
					if (d_done)
						state_q <= S_UPD;
				end
				S_UPD: begin
					ea_q    <= e_next;
					cang_q  <= e_next[31:0];
					cst_q   <= 1'b1;
					cnt_q   <= cnt_q + 8'd1;
					state_q <= S_CRDE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_IDLE && start) begin
				e_q   <= VAL_W'(e_sat);
				neg_q <= m_sat[31];
				red_q <= {2'b0, (m_sat[31] ? 32'(-33'(m_sat)) : 32'(m_sat)), 30'd0};
				mod_q <= TWOPI_RED << 7;
			end
		end
	end

	assign busy              = (state_q != S_IDLE);
	assign done              = done_q;
	assign eccentric_anomaly = res_ea_q;
	assign status            = res_st_q;
	assign iterations_used   = res_it_q;

endmodule

FILE: rtl/kea_mul.sv
module kea_mul (
	input  logic                              clk,
	input  logic signed [kea_pkg::VAL_W-1:0]  a,
	input  logic signed [kea_pkg::VAL_W-1:0]  b,
	output logic signed [kea_pkg::PROD_W-1:0] p_q
);
	import kea_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

FILE: rtl/kea_cordic.sv
module kea_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [31:0]                      angle,
	output logic                             done,
	output logic signed [kea_pkg::VAL_W-1:0] sin_v,
	output logic signed [kea_pkg::VAL_W-1:0] cos_v
);
	import kea_pkg::*;

	logic signed [VAL_W-1:0] x_q, y_q, z_q;
	logic signed [VAL_W-1:0] z0, z1;
	logic [4:0] i_q;
	logic run_q, done_q, neg_q, neg0;

	// fold the angle into [-pi/2, pi/2]
	always_comb begin
		z0 = VAL_W'({angle, 1'b0});
		neg0 = 1'b0;
		if (z0 > PI_Q30)
			z0 = z0 - TWOPI_Q30;
		z1 = z0;
		if (z0 > HALFPI_Q30) begin
			z1 = z0 - PI_Q30;
			neg0 = 1'b1;
		end else if (z0 < -HALFPI_Q30) begin
			z1 = z0 + PI_Q30;
			neg0 = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_K;
			y_q   <= '0;
			z_q   <= z1;
			neg_q <= neg0;
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> i_q);
				y_q <= y_q + (x_q >>> i_q);
				z_q <= z_q - atan_q30(i_q);
			end else begin
				x_q <= x_q + (y_q >>> i_q);
				y_q <= y_q - (x_q >>> i_q);
				z_q <= z_q + atan_q30(i_q);
			end
		end
	end

	assign done  = done_q;
	assign sin_v = neg_q ? -y_q : y_q;
	assign cos_v = neg_q ? -x_q : x_q;

endmodule

FILE: rtl/kea_div.sv
module kea_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [kea_pkg::DVD_W-1:0]  dividend,
	input  logic [kea_pkg::DVS_W-1:0]  divisor,
	output logic                       done,
	output logic [kea_pkg::DVD_W-1:0]  quot
);
	import kea_pkg::*;

	localparam int CW = $clog2(DVD_W);

	logic [DVD_W-1:0] q_q;
	logic [DVS_W-1:0] r_q, dvs_q;
	logic [DVS_W:0]   sh, diff;
	logic [CW-1:0]    n_q;
	logic run_q, done_q;

	assign sh   = {r_q, q_q[DVD_W-1]};
	assign diff = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			n_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				n_q   <= '0;
			end else if (run_q) begin
				n_q <= n_q + CW'(1);
				if (n_q == CW'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			r_q   <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!diff[DVS_W]) begin
				r_q <= diff[DVS_W-1:0];
				q_q <= {q_q[DVD_W-2:0], 1'b1};
			end else begin
				r_q <= sh[DVS_W-1:0];
				q_q <= {q_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import kea_pkg::*;

	typedef struct packed {
		logic [31:0] anomaly;
		logic [1:0]  st;
		logic [7:0]  iters;
	} solution_t;

	localparam longint Q30_ONE   = 64'sd1073741824;
	localparam longint Q30_HALF  = 64'sd536870912;
	localparam longint TWOPI_56  = 64'sh006487ED5110B461;
	localparam longint E_MAX     = 64'sd3373259425;
	localparam longint PI_30     = 64'sd3373259426;
	localparam longint TWOPI_30  = 64'sd6746518852;
	localparam longint HALFPI_30 = 64'sd1686629713;
	localparam longint GAIN_INV  = 64'sh26DD3B6A;
	localparam longint ARCTAN [30] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] eccentricity;
	logic signed [31:0] mean_anomaly;
	logic               cfg_we;
	logic               cfg_index;
	logic [15:0]        cfg_data;
	logic               done;
	logic [31:0]        eccentric_anomaly;
	logic [1:0]         status;
	logic [7:0]         iterations_used;

	solution_t   pending_solutions[$];
	logic [7:0]  iter_limit;
	logic [15:0] tol_limit;
	int          mismatches;
	int          words_sent;
	int          words_checked;
	int          sender_idle_pct;

	kepler_eccentric_anomaly_solver i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.eccentricity(eccentricity), .mean_anomaly(mean_anomaly),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .eccentric_anomaly(eccentric_anomaly), .status(status),
		.iterations_used(iterations_used)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// rotation-mode cordic, angle in q.29 within [0, 2*pi)
	task automatic cordic_sin_cos(input longint a29, output longint s, output longint c);
		longint z, x, y, nx;
		bit neg;
		z = a29 * 2;
		x = GAIN_INV;
		y = 0;
		neg = 0;
		if (z > PI_30) z -= TWOPI_30;
		if (z > HALFPI_30) begin
			z -= PI_30;
			neg = 1;
		end else if (z < -HALFPI_30) begin
			z += PI_30;
			neg = 1;
		end
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARCTAN[i];
			end
			x = nx;
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endtask

	task automatic solve_kepler(input logic signed [31:0] ecc_in,
			input logic signed [31:0] ma_in, output solution_t sol);
		longint e, r, m, sm, cm, es, ec, e2, c2, t2, t3, t4, g2, ea, se, ce, f, d, nv, tol;
		int unsigned cnt;
		e = ecc_in;
		tol = tol_limit;
		cnt = 0;
		if (e < 0 || e >= Q30_ONE) begin
			sol = '{anomaly: 32'd0, st: ST_INVALID, iters: 8'd0};
			return;
		end
		r = (longint'(ma_in) * Q30_ONE) % TWOPI_56;
		if (r < 0) r += TWOPI_56;
		m = r >>> 27;
		cordic_sin_cos(m, sm, cm);
		es = (e * sm) >>> 30;
		ec = (e * cm) >>> 30;
		e2 = (e * e) >>> 30;
		c2 = (cm * cm) >>> 30;
		t2 = (es * ec) >>> 30;
		t3 = (e2 * es) >>> 30;
		t4 = ((3 * c2) >>> 1) - Q30_HALF;
		g2 = (t3 * t4) >>> 30;
		ea = m + ((es + t2 + g2) >>> 1);
		if (ea < 0) ea = 0;
		if (ea > E_MAX) ea = E_MAX;
		cordic_sin_cos(ea, se, ce);
		f = ea - m - ((e * se) >>> 31);
		while (cnt < iter_limit && (f < 0 ? -f : f) > tol) begin
			d = Q30_ONE - ((e * ce) >>> 30);
			if (d < 1) d = 1;
			nv = ea - (f * Q30_ONE) / d;
			// out-of-range newton step falls back to bisection toward the bound
			if (nv > E_MAX) nv = (ea + E_MAX) / 2;
			if (nv < 0) nv = ea / 2;
			ea = nv;
			cordic_sin_cos(ea, se, ce);
			f = ea - m - ((e * se) >>> 31);
			cnt++;
		end
		sol.anomaly = ea[31:0];
		sol.st = (cnt == iter_limit && (f < 0 ? -f : f) > tol) ? ST_LIMIT : ST_CONVERGED;
		sol.iters = cnt[7:0];
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_solutions.size() == 0) begin
				report_mismatch("unexpected result word", eccentric_anomaly, -1);
			end else begin
				solution_t want;
				want = pending_solutions.pop_front();
				if (eccentric_anomaly !== want.anomaly)
					report_mismatch("eccentric_anomaly", eccentric_anomaly, want.anomaly);
				if (status !== want.st)
					report_mismatch("status", status, want.st);
				if (iterations_used !== want.iters)
					report_mismatch("iterations_used", iterations_used, want.iters);
				words_checked++;
			end
		end
	end

	task automatic send_word(input logic signed [31:0] ecc_in, input logic signed [31:0] ma_in);
		solution_t sol;
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		start = 1'b1;
		eccentricity = ecc_in;
		mean_anomaly = ma_in;
		solve_kepler(ecc_in, ma_in, sol);
		do @(posedge clk); while (busy);
		pending_solutions.push_back(sol);
		words_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_solutions.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == REG_MAX_ITER) iter_limit = val[7:0];
		else tol_limit = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic signed [31:0] random_ecc();
		if ($urandom_range(9) == 0) return $urandom();
		return $urandom_range(32'h3FFF_FFFF, 0);
	endfunction

	task automatic test_directed();
		send_word(32'sd0, 32'sd0);
		send_word(32'sd0, 32'sh7FFF_FFFF);
		send_word(32'sh3FFF_FFFF, 32'sh8000_0000);
		send_word(32'sh3FFF_FFFF, 32'sh7FFF_FFFF);
		send_word(32'sh3FFF_FFFF, 32'sd1);
		send_word(32'sh3FFF_FFFF, -32'sd1);
		send_word(32'sh3FFF_FFFF, 32'sd0);
		send_word(32'sh4000_0000, 32'sd12345);
		send_word(32'sh7FFF_FFFF, 32'sd0);
		send_word(-32'sd1, 32'sd100);
		send_word(32'sh8000_0000, 32'sh8000_0000);
		// m just below and just above 2*pi in q5.26
		send_word(32'sh2000_0000, 32'sd421657428);
		send_word(32'sh2000_0000, 32'sd421657429);
		send_word(32'sh3F00_0000, 32'sd210828714);
		send_word(32'sh3800_0000, 32'sd3);
		send_word(32'sh3800_0000, 32'sd421657420);
		send_word(32'sh0000_0001, 32'sh5555_5555);
		send_word(32'sh2AAA_AAAA, 32'shAAAA_AAAA);
		drain_results();
	endtask

	task automatic test_random_phase(input int n, input int idle_pct);
		sender_idle_pct = idle_pct;
		repeat (n) send_word(random_ecc(), $urandom());
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		eccentricity = '0;
		mean_anomaly = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		iter_limit = ITER_RESET;
		tol_limit = TOL_RESET;
		mismatches = 0;
		words_sent = 0;
		words_checked = 0;
		sender_idle_pct = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_phase(250, 12);
		write_reg(REG_MAX_ITER, 16'hFFFF);
		write_reg(REG_TOL, 16'hFFFF);
		test_directed();
		test_random_phase(250, 74);
		write_reg(REG_MAX_ITER, 16'hA501);
		write_reg(REG_TOL, 16'd0);
		test_directed();
		test_random_phase(200, 0);
		write_reg(REG_MAX_ITER, {8'($urandom_range(255, 0)), 8'd6});
		write_reg(REG_TOL, 16'($urandom_range(3, 0)));
		test_random_phase(150, 12);
		repeat (4) begin
			write_reg(REG_MAX_ITER, {8'($urandom_range(255, 0)),
				8'($urandom_range(255, 1))});
			write_reg(REG_TOL, 16'($urandom_range(65535, 4)));
			test_random_phase(80, $urandom_range(2, 0) == 0 ? 74 : 0);
		end

		$display("sent %0d words, checked %0d results across eight register settings",
			words_sent, words_checked);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000_000;
		$display("timeout with %0d results outstanding", pending_solutions.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/kea_pkg.sv
rtl/kea_mul.sv
rtl/kea_cordic.sv
rtl/kea_div.sv
rtl/kepler_eccentric_anomaly_solver.sv
tb/testbench.sv
